// ----- src/i2crw_pkg.sv -----
// ----------------------------------------------------------------------------
// i2crw_pkg
// Shared types and constants of the I2C register write master.
// ----------------------------------------------------------------------------
package i2crw_pkg;

	localparam int unsigned ADDR_W    = 8;
	localparam int unsigned TMO_W     = 10;
	localparam int unsigned DLY_W     = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 10;

	localparam logic [ADDR_W-1:0] ADDR_RST = 8'd120;
	localparam logic [TMO_W-1:0]  TMO_RST  = 10'd100;
	localparam logic [DLY_W-1:0]  DLY_RST  = 8'd1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_DELAY = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_A   = 4'd1,
		PH_START_B   = 4'd2,
		PH_BIT_SETUP = 4'd3,
		PH_BIT_HIGH  = 4'd4,
		PH_BIT_LOW   = 4'd5,
		PH_ACK_SET   = 4'd6,
		PH_ACK_POLL  = 4'd7,
		PH_STOP_A    = 4'd8,
		PH_STOP_B    = 4'd9,
		PH_STOP_C    = 4'd10
	} phase_t;

	typedef struct packed {
		logic [ADDR_W-1:0] device_address;
		logic [TMO_W-1:0]  ack_timeout;
		logic [DLY_W-1:0]  ticks_per_delay;
	} cfg_t;

	typedef struct packed {
		logic ack_error;
		logic done;
		logic busy;
		logic sda;
		logic scl;
	} res_t;

endpackage

// ----- src/i2crw_seq.sv -----
// ----------------------------------------------------------------------------
// i2crw_seq
// Bus sequencer: advances one tick per request and forms the line levels.
// ----------------------------------------------------------------------------
module i2crw_seq import i2crw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  cfg_t       cfg,
	input  logic       cmd,
	input  logic [7:0] control_byte,
	input  logic [7:0] payload_byte,
	input  logic       sda_sample,
	output res_t       res
);

	phase_t            phase_q, phase_n;
	logic [2:0]        bit_count_q, bit_count_n;
	logic [1:0]        byte_index_q, byte_index_n;
	logic [7:0]        shift_byte_q, shift_byte_n;
	logic [7:0]        held_control_q, held_control_n;
	logic [7:0]        held_payload_q, held_payload_n;
	logic [DLY_W-1:0]  delay_q, delay_n;
	logic [TMO_W-1:0]  poll_q, poll_n;
	logic              err_q, err_n;

	logic [DLY_W-1:0]  unit_len;
	logic              unit_over;
	logic [DLY_W-1:0]  delay_adv;
	logic [TMO_W:0]    poll_inc;
	logic [1:0]        byte_index_inc;
	logic              done_n, errout_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bit_count_q    <= '0;
			byte_index_q   <= '0;
			shift_byte_q   <= '0;
			held_control_q <= '0;
			held_payload_q <= '0;
			delay_q        <= '0;
			poll_q         <= '0;
			err_q          <= 1'b0;
		end else if (step) begin
			phase_q        <= phase_n;
			bit_count_q    <= bit_count_n;
			byte_index_q   <= byte_index_n;
			shift_byte_q   <= shift_byte_n;
			held_control_q <= held_control_n;
			held_payload_q <= held_payload_n;
			delay_q        <= delay_n;
			poll_q         <= poll_n;
			err_q          <= err_n;
		end
	end

	// zero delay setting counts as one tick
	assign unit_len       = (cfg.ticks_per_delay == '0) ? DLY_W'(1) : cfg.ticks_per_delay;
	assign unit_over      = ({1'b0, delay_q} + (DLY_W+1)'(1)) >= {1'b0, unit_len};
	assign delay_adv      = unit_over ? '0 : delay_q + DLY_W'(1);
	assign poll_inc       = {1'b0, poll_q} + (TMO_W+1)'(1);
	assign byte_index_inc = byte_index_q + 2'd1;

	always_comb begin
		phase_n        = phase_q;
		bit_count_n    = bit_count_q;
		byte_index_n   = byte_index_q;
		shift_byte_n   = shift_byte_q;
		held_control_n = held_control_q;
		held_payload_n = held_payload_q;
		delay_n        = delay_adv;
		poll_n         = poll_q;
		err_n          = err_q;
		done_n         = 1'b0;
		errout_n       = 1'b0;
		case (phase_q)
			PH_START_A: begin
				if (unit_over) phase_n = PH_START_B;
			end
			PH_START_B: begin
				if (unit_over) phase_n = PH_BIT_SETUP;
			end
			PH_BIT_SETUP: begin
				if (unit_over) phase_n = PH_BIT_HIGH;
			end
			PH_BIT_HIGH: begin
				if (unit_over) phase_n = PH_BIT_LOW;
			end
			PH_BIT_LOW: begin
				if (unit_over) begin
					shift_byte_n = {shift_byte_q[6:0], 1'b0};
					if (bit_count_q == 3'd7) begin
						bit_count_n = '0;
						phase_n     = PH_ACK_SET;
					end else begin
						bit_count_n = bit_count_q + 3'd1;
						phase_n     = PH_BIT_SETUP;
					end
				end
			end
			PH_ACK_SET: begin
				if (unit_over) begin
					poll_n  = '0;
					phase_n = PH_ACK_POLL;
				end
			end
			PH_ACK_POLL: begin
				delay_n = delay_q;
				if (!sda_sample) begin
					poll_n  = '0;
					delay_n = '0;
					if (byte_index_q >= 2'd2) begin
						phase_n = PH_STOP_A;
					end else begin
						byte_index_n = byte_index_inc;
						shift_byte_n = (byte_index_inc == 2'd1) ? held_control_q
						                                        : held_payload_q;
						bit_count_n  = '0;
						phase_n      = PH_BIT_SETUP;
					end
				end else if (poll_inc > {1'b0, cfg.ack_timeout}) begin
					// no acknowledge in time: single stop, flag the error
					poll_n  = '0;
					delay_n = '0;
					err_n   = 1'b1;
					phase_n = PH_STOP_A;
				end else begin
					poll_n = poll_inc[TMO_W-1:0];
				end
			end
			PH_STOP_A: begin
				if (unit_over) phase_n = PH_STOP_B;
			end
			PH_STOP_B: begin
				if (unit_over) phase_n = PH_STOP_C;
			end
			PH_STOP_C: begin
				if (unit_over) begin
					done_n       = 1'b1;
					errout_n     = err_q;
					err_n        = 1'b0;
					byte_index_n = '0;
					phase_n      = PH_IDLE;
				end
			end
			default: begin
				// idle, and any unused code
				phase_n = PH_IDLE;
				delay_n = '0;
				if (cmd) begin
					held_control_n = control_byte;
					held_payload_n = payload_byte;
					shift_byte_n   = cfg.device_address;
					bit_count_n    = '0;
					byte_index_n   = '0;
					poll_n         = '0;
					err_n          = 1'b0;
					phase_n        = PH_START_A;
				end
			end
		endcase
	end

	// line levels after this tick
	always_comb begin
		res.scl       = 1'b1;
		res.sda       = 1'b1;
		res.busy      = (phase_n != PH_IDLE);
		res.done      = done_n;
		res.ack_error = errout_n;
		case (phase_n)
			PH_START_B: begin
				res.scl = 1'b1;
				res.sda = 1'b0;
			end
			PH_BIT_SETUP, PH_BIT_LOW: begin
				res.scl = 1'b0;
				res.sda = shift_byte_n[7];
			end
			PH_BIT_HIGH: begin
				res.scl = 1'b1;
				res.sda = shift_byte_n[7];
			end
			PH_STOP_A: begin
				res.scl = 1'b0;
				res.sda = 1'b0;
			end
			PH_STOP_B: begin
				res.scl = 1'b1;
				res.sda = 1'b0;
			end
			default: begin
				res.scl = 1'b1;
				res.sda = 1'b1;
			end
		endcase
	end

	a_err_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.ack_error |-> res.done && !res.busy)
		else $error("ack_error without done");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_IDLE && cmd |=> phase_q == PH_START_A)
		else $error("start request not taken in idle");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bit_count_q == '0 && byte_index_q == '0 && !err_q)
		else $error("stale counters in idle");

	a_poll_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_ACK_POLL |-> poll_q == '0)
		else $error("poll count left over outside acknowledge poll");

endmodule

// ----- src/i2c_register_write_master.sv -----
// ----------------------------------------------------------------------------
// i2c_register_write_master
// I2C master sending start, device address, control byte, data byte, stop.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the slave stream is one bus tick. s_tuser is the command
// (1 = start a write if idle); s_tdata carries the control and data bytes,
// latched at start, and the sampled SDA level used while polling for an
// acknowledge. Every request yields exactly one result on the master stream
// with the SCL/SDA levels, busy, a one-tick done pulse and ack_error.
// The result of a request is in the output register on the cycle after it is
// accepted. Throughput is one request per cycle unless the receiver stalls; the
// sequencer next-state logic is the only path from input to output register.
// When the receiver stalls, the output register holds its result and
// s_tready drops until it is taken; the sequencer does not advance meanwhile.
// Reset clears the sequencer to idle and loads the register defaults:
// device address 120, acknowledge timeout 100, one tick per delay unit.
// A missing acknowledge on any byte ends the transfer with one stop and
// ack_error set on the done result.
// ----------------------------------------------------------------------------
module i2c_register_write_master import i2crw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // control_byte[7:0], payload_byte[15:8],
	                                        // sda_sample[16], zero [23:17]
	input  logic                 s_tuser,   // cmd[0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // scl_drive[0], sda_drive[1], busy_res[2],
	                                        // done_res[3], ack_error[4], zero [7:5]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t cfg_q;
	res_t res;
	res_t out_q;
	logic out_valid_q;
	logic step;

	// configuration registers; writes to an unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address  <= ADDR_RST;
			cfg_q.ack_timeout     <= TMO_RST;
			cfg_q.ticks_per_delay <= DLY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEV_ADDR:    cfg_q.device_address  <= cfg_data[ADDR_W-1:0];
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout     <= cfg_data[TMO_W-1:0];
				CFG_TICKS_DELAY: cfg_q.ticks_per_delay <= cfg_data[DLY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// take a new tick whenever the output slot is free or being emptied
	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	i2crw_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.cfg          (cfg_q),
		.cmd          (s_tuser),
		.control_byte (s_tdata[7:0]),
		.payload_byte (s_tdata[15:8]),
		.sda_sample   (s_tdata[16]),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.ack_error, out_q.done, out_q.busy, out_q.sda, out_q.scl};

endmodule
